[rtl/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// ffha_pkg: shared definitions for the first-fit heap allocator
// Heap geometry constants, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int HEAP_MAX_BYTES_DEF  = 65536;
  localparam int MIN_SPLIT_BYTES_DEF = 8;
  localparam int ALIGN_BYTES         = 4;
  localparam int ALIGN_SHIFT         = 2;
  localparam int HEADER_BYTES        = 8;
  localparam int EPOCH_W             = 12;

  localparam logic [16:0] HEAP_BYTES_RESET = 17'h10000;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_BADPTR = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_FORM,
    S_CLR,
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_A_WSPL,
    S_A_WCUR,
    S_A_LINK,
    S_F_CHK,
    S_F_WALK,
    S_F_WRD,
    S_F_NCHK,
    S_F_WU,
    S_F_WP,
    S_FIN
  } state_t;

endpackage

[rtl/ffha_ram.sv]
// ----------------------------------------------------------------------------
// ffha_ram: header store of the heap allocator
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module ffha_ram import ffha_pkg::*; #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14,
  parameter int DW    = 45
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/first_fit_heap_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator: first-fit heap allocator with coalescing
// Keeps block headers and an address-ordered free list in an on-chip store
// and serves allocate and free requests one at a time.
// ----------------------------------------------------------------------------
// Usage. A request is one transfer on the input channel (in_valid/in_ready):
// func selects allocate (request_size bytes) or free (block at data_offset).
// Every request yields exactly one transfer on the output channel
// (out_valid/out_ready) with a status, the granted data offset, the free byte
// count and the success counters.
// Operation. One request at a time; the block is not ready while it works. Each
// free-list step is a header read and then a check of the registered read
// data. An allocate walks the free list to the first block that fits, then
// writes the split header (on a split), the granted header and the link of
// the preceding free block. A free checks the used mark and epoch, walks the
// list to its place, reads the following block if it touches, then writes its
// own header and the preceding block's. A request rejected on its fields goes
// straight to the result, a free rejected on the used mark after its header read.
// Reset and configuration. After reset, and after every transfer on the
// configuration channel (cfg_valid/cfg_ready/heap_bytes), the block forms the
// heap. Once in 4096 configuration transfers the header store is first cleared,
// one entry a cycle, so old headers never look current.
// Configuration is taken only while idle and wins over a request in that cycle.
// Stalls. A finished result waits in the output register; the block may take
// the next request meanwhile and holds its own result until the first leaves.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int HEAP_MAX_BYTES  = HEAP_MAX_BYTES_DEF,
  parameter int MIN_SPLIT_BYTES = MIN_SPLIT_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] heap_bytes,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [16:0] request_size,
  input  logic [15:0] data_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] granted_offset,
  output logic [16:0] free_byte_count,
  output logic [31:0] alloc_total,
  output logic [31:0] free_total
);

  // Store geometry: one header slot per four-byte unit. A link equal to the
  // unit count means the end of the free list.
  localparam int UNITS = HEAP_MAX_BYTES / ALIGN_BYTES;
  localparam int UW    = $clog2(UNITS);
  localparam int LW    = UW + 1;
  localparam int SZW   = $clog2(HEAP_MAX_BYTES + 1);
  localparam int NW    = 18;
  localparam int CW    = (SZW > NW) ? SZW : NW;
  localparam int WW    = 1 + EPOCH_W + LW + SZW;
  localparam logic [LW-1:0] NONE      = LW'(UNITS);
  localparam logic [CW-1:0] SPLIT_MIN = CW'(HEADER_BYTES + MIN_SPLIT_BYTES);

  state_t state, state_next;

  logic [16:0]        heap_cfg;
  logic [EPOCH_W-1:0] epoch;
  logic               heap_ready;
  logic [SZW-1:0]     heap_end;
  logic [LW-1:0]      free_head;
  logic [SZW-1:0]     free_bytes;
  logic [31:0]        alloc_count;
  logic [31:0]        free_count;

  // Per-request working registers.
  logic [NW-1:0]  need;
  logic [LW-1:0]  cur;
  logic [LW-1:0]  prev;
  logic [SZW-1:0] prev_sz;
  logic [UW-1:0]  u;
  logic [SZW-1:0] usize;
  logic [LW-1:0]  unext;
  logic [LW-1:0]  link_tgt;
  logic [SZW-1:0] cur_sz;
  logic [LW-1:0]  split_u;
  logic [SZW-1:0] split_sz;
  logic [LW-1:0]  split_nxt;
  logic           do_split;
  status_t        res_status;
  logic [15:0]    res_granted;
  logic [UW-1:0]  clr_addr;

  // Header store port.
  logic          mem_we;
  logic [UW-1:0] mem_waddr;
  logic [WW-1:0] mem_wdata;
  logic [UW-1:0] mem_raddr;
  logic [WW-1:0] mem_rdata;

  ffha_ram #(
    .DEPTH(UNITS),
    .AW   (UW),
    .DW   (WW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Header word fields: used mark, formation epoch, free link, size.
  logic [SZW-1:0]     rd_size;
  logic [LW-1:0]      rd_next;
  logic [EPOCH_W-1:0] rd_epoch;
  logic               rd_used;

  assign rd_size  = mem_rdata[SZW-1:0];
  assign rd_next  = mem_rdata[SZW+LW-1:SZW];
  assign rd_epoch = mem_rdata[SZW+LW+EPOCH_W-1:SZW+LW];
  assign rd_used  = mem_rdata[WW-1];

  // Heap size as formed: clamped to the store and rounded down to a unit.
  logic [CW-1:0]  hb_cw;
  logic [CW-1:0]  h_cw;
  logic           form_ok;

  always_comb begin
    hb_cw = CW'(heap_cfg);
    if (hb_cw > CW'(HEAP_MAX_BYTES)) begin
      hb_cw = CW'(HEAP_MAX_BYTES);
    end
    h_cw    = hb_cw & ~CW'(ALIGN_BYTES - 1);
    form_ok = h_cw >= SPLIT_MIN;
  end

  // Request decode at acceptance.
  logic [NW-1:0]  need_in;
  logic [CW-1:0]  b_cw;
  logic [UW-1:0]  u_in;
  logic           ptr_ok;
  logic           in_fire;
  logic           cfg_fire;

  assign in_fire  = in_valid && in_ready;
  assign cfg_fire = cfg_valid && cfg_ready;

  always_comb begin
    need_in = ((NW'(request_size) + NW'(ALIGN_BYTES - 1)) & ~NW'(ALIGN_BYTES - 1))
              + NW'(HEADER_BYTES);
    b_cw    = CW'(data_offset) - CW'(HEADER_BYTES);
    u_in    = b_cw[UW+ALIGN_SHIFT-1:ALIGN_SHIFT];
    ptr_ok  = heap_ready && (data_offset >= 16'(HEADER_BYTES))
              && (data_offset[ALIGN_SHIFT-1:0] == '0) && (b_cw < CW'(heap_end));
  end

  // Fit test on the header just read during the allocate walk.
  logic          fit;
  logic [CW-1:0] rem;
  logic [CW-1:0] nu_cw;
  logic          split_ok;

  always_comb begin
    fit      = CW'(rd_size) >= CW'(need);
    rem      = CW'(rd_size) - CW'(need);
    nu_cw    = CW'(cur) + CW'(need >> ALIGN_SHIFT);
    split_ok = (rem >= SPLIT_MIN) && (nu_cw < CW'(UNITS));
  end

  // Free walk and merge tests.
  logic          walk_go;
  logic [LW-1:0] end_u;
  logic          nmerge;
  logic          pmerge;

  always_comb begin
    walk_go = (cur < NONE) && (cur < LW'(u));
    end_u   = LW'(u) + LW'(usize >> ALIGN_SHIFT);
    nmerge  = ((CW'(end_u) << ALIGN_SHIFT) < CW'(heap_end)) && (cur < NONE)
              && (cur == end_u);
    pmerge  = (prev < NONE) && ((LW'(prev) + LW'(prev_sz >> ALIGN_SHIFT)) == LW'(u));
  end

  logic out_load;

  // A configuration transfer takes the idle cycle, so a request waits then.
  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign out_load  = (state == S_FIN) && (!out_valid || out_ready);

  // Sequencer: next state and store port.
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_raddr  = cur[UW-1:0];
    case (state)
      S_FORM: begin
        mem_we     = form_ok;
        mem_wdata  = {1'b0, epoch, NONE, SZW'(h_cw)};
        state_next = S_IDLE;
      end
      S_CLR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_addr;
        state_next = (clr_addr == UW'(UNITS - 1)) ? S_FORM : S_CLR;
      end
      S_IDLE: begin
        mem_raddr = u_in;
        if (cfg_fire) begin
          state_next = (&epoch) ? S_CLR : S_FORM;
        end else if (in_fire) begin
          if (func == FUNC_FREE) begin
            state_next = ptr_ok ? S_F_CHK : S_FIN;
          end else begin
            state_next = (heap_ready && request_size != '0) ? S_A_RD : S_FIN;
          end
        end
      end
      S_A_RD: begin
        state_next = (cur < NONE) ? S_A_CHK : S_FIN;
      end
      S_A_CHK: begin
        if (fit) begin
          state_next = split_ok ? S_A_WSPL : S_A_WCUR;
        end else begin
          state_next = S_A_RD;
        end
      end
      S_A_WSPL: begin
        mem_we     = 1'b1;
        mem_waddr  = split_u[UW-1:0];
        mem_wdata  = {1'b0, epoch, split_nxt, split_sz};
        state_next = S_A_WCUR;
      end
      S_A_WCUR: begin
        mem_we     = 1'b1;
        mem_waddr  = cur[UW-1:0];
        mem_wdata  = {1'b1, epoch, NONE, cur_sz};
        state_next = S_A_LINK;
      end
      S_A_LINK: begin
        mem_we     = (prev < NONE);
        mem_waddr  = prev[UW-1:0];
        mem_wdata  = {1'b0, epoch, link_tgt, prev_sz};
        state_next = S_FIN;
      end
      S_F_CHK: begin
        state_next = (rd_used && rd_epoch == epoch) ? S_F_WALK : S_FIN;
      end
      S_F_WALK: begin
        if (walk_go) begin
          state_next = S_F_WRD;
        end else if (nmerge) begin
          state_next = S_F_NCHK;
        end else begin
          state_next = S_F_WU;
        end
      end
      S_F_WRD: begin
        state_next = S_F_WALK;
      end
      S_F_NCHK: begin
        state_next = S_F_WU;
      end
      S_F_WU: begin
        mem_we     = 1'b1;
        mem_waddr  = u;
        mem_wdata  = {1'b0, epoch, unext, usize};
        state_next = S_F_WP;
      end
      S_F_WP: begin
        mem_we    = (prev < NONE);
        mem_waddr = prev[UW-1:0];
        if (pmerge) begin
          mem_wdata = {1'b0, epoch, unext, prev_sz + usize};
        end else begin
          mem_wdata = {1'b0, epoch, LW'(u), prev_sz};
        end
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FORM;
    end else begin
      state <= state_next;
    end
  end

  // Heap-wide state.
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_cfg    <= HEAP_BYTES_RESET;
      epoch       <= '0;
      heap_ready  <= 1'b0;
      heap_end    <= '0;
      free_head   <= NONE;
      free_bytes  <= '0;
      alloc_count <= '0;
      free_count  <= '0;
    end else begin
      case (state)
        S_FORM: begin
          heap_ready  <= form_ok;
          heap_end    <= form_ok ? SZW'(h_cw) : '0;
          free_head   <= form_ok ? '0 : NONE;
          free_bytes  <= form_ok ? SZW'(h_cw - CW'(HEADER_BYTES)) : '0;
          alloc_count <= '0;
          free_count  <= '0;
        end
        S_IDLE: begin
          if (cfg_fire) begin
            heap_cfg <= heap_bytes;
            epoch    <= epoch + 1'b1;
          end
        end
        S_A_CHK: begin
          if (fit) begin
            alloc_count <= alloc_count + 1'b1;
            if (split_ok) begin
              free_bytes <= free_bytes - SZW'(need);
            end else begin
              free_bytes <= free_bytes - (rd_size - SZW'(HEADER_BYTES));
            end
          end
        end
        S_A_LINK: begin
          if (!(prev < NONE)) begin
            free_head <= link_tgt;
          end
        end
        S_F_CHK: begin
          if (rd_used && rd_epoch == epoch) begin
            free_count <= free_count + 1'b1;
            free_bytes <= free_bytes + (rd_size - SZW'(HEADER_BYTES));
          end
        end
        S_F_NCHK: begin
          free_bytes <= free_bytes + SZW'(HEADER_BYTES);
        end
        S_F_WP: begin
          if (pmerge) begin
            free_bytes <= free_bytes + SZW'(HEADER_BYTES);
          end else if (!(prev < NONE)) begin
            free_head <= LW'(u);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Per-request working registers; payload only, no reset needed.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        need        <= need_in;
        u           <= u_in;
        cur         <= free_head;
        prev        <= NONE;
        prev_sz     <= '0;
        res_granted <= '0;
        clr_addr    <= '0;
        if (func == FUNC_FREE) begin
          res_status <= ST_BADPTR;
        end else begin
          res_status <= ST_NOFIT;
        end
      end
      S_CLR: begin
        clr_addr <= clr_addr + 1'b1;
      end
      S_A_CHK: begin
        if (fit) begin
          res_status  <= ST_OK;
          res_granted <= 16'((CW'(cur) << ALIGN_SHIFT) + CW'(HEADER_BYTES));
          do_split    <= split_ok;
          split_u     <= LW'(nu_cw);
          split_sz    <= SZW'(rem);
          split_nxt   <= rd_next;
          cur_sz      <= split_ok ? SZW'(need) : rd_size;
          link_tgt    <= split_ok ? LW'(nu_cw) : rd_next;
        end else begin
          prev    <= cur;
          prev_sz <= rd_size;
          cur     <= rd_next;
        end
      end
      S_F_CHK: begin
        res_status <= (rd_used && rd_epoch == epoch) ? ST_OK : ST_BADPTR;
        usize      <= rd_size;
      end
      S_F_WALK: begin
        unext <= cur;
      end
      S_F_WRD: begin
        prev    <= cur;
        prev_sz <= rd_size;
        cur     <= rd_next;
      end
      S_F_NCHK: begin
        usize <= usize + rd_size;
        unext <= rd_next;
      end
      default: begin
      end
    endcase
  end

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status          <= res_status;
      granted_offset  <= res_granted;
      free_byte_count <= 17'(free_bytes);
      alloc_total     <= alloc_count;
      free_total      <= free_count;
    end
  end

  // The split store is written only on a split grant.
  a_split_only: assert property (@(posedge clk) disable iff (rst)
    (state == S_A_WSPL) |-> do_split)
    else $error("split header written without a split");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("request taken while a request is in work");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("header store written while idle");

  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (granted_offset == '0))
    else $error("failed request reports a granted offset");

  a_empty_heap: assert property (@(posedge clk) disable iff (rst)
    (!heap_ready && state != S_FORM) |-> (free_bytes == '0))
    else $error("free bytes counted without a heap");

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for the first-fit heap allocator
// Drives allocate and free requests over valid/ready and rewrites the heap
// size between phases. A heap model inside the bench predicts every result,
// and the monitor compares each output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import ffha_pkg::*;

  localparam int UNITS   = 65536 / ALIGN_BYTES;
  localparam int NONE    = UNITS;
  localparam int MIN_REM = HEADER_BYTES + MIN_SPLIT_BYTES_DEF;

  typedef struct {
    status_t     status;
    logic [15:0] granted;
    logic [16:0] free_bytes;
    logic [31:0] allocs;
    logic [31:0] frees;
  } result_t;

  // One row of the directed table. When typed is set, status and granted
  // are written out by hand and override the heap model for those fields.
  typedef struct {
    logic        func;
    logic [16:0] size;
    logic [15:0] offset;
    bit          typed;
    status_t     status;
    logic [15:0] granted;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [16:0] heap_bytes = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = FUNC_ALLOC;
  logic [16:0] request_size = '0;
  logic [15:0] data_offset = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [15:0] granted_offset;
  logic [16:0] free_byte_count;
  logic [31:0] alloc_total;
  logic [31:0] free_total;

  // Heap model state: one header entry per four-byte unit.
  logic [16:0] unit_size [UNITS];
  logic        unit_used [UNITS];
  logic [14:0] unit_next [UNITS];
  // Units whose header the block has written at least once since reset.
  bit          unit_seen [UNITS];
  int          list_head;
  int          heap_limit;
  bit          heap_formed;
  logic [16:0] free_sum;
  logic [31:0] alloc_tally;
  logic [31:0] free_tally;

  result_t     pending_q[$];
  logic [15:0] live_q[$];
  int          err_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  always #6 clk = ~clk;

  first_fit_heap_allocator u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .heap_bytes(heap_bytes),
    .in_valid(in_valid), .in_ready(in_ready), .func(func),
    .request_size(request_size), .data_offset(data_offset),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .granted_offset(granted_offset), .free_byte_count(free_byte_count),
    .alloc_total(alloc_total), .free_total(free_total)
  );

  // Rebuild the heap as one free block (no heap if the size is too small) and clear the counters.
  function automatic void form_heap(logic [16:0] size_reg);
    int h;
    h = (size_reg > 17'd65536) ? 65536 : int'(size_reg);
    h = h & ~(ALIGN_BYTES - 1);
    for (int i = 0; i < UNITS; i++) begin
      unit_size[i] = '0;
      unit_used[i] = 1'b0;
      unit_next[i] = '0;
    end
    alloc_tally = '0;
    free_tally = '0;
    if (h < MIN_REM) begin
      heap_formed = 0;
      heap_limit = 0;
      list_head = NONE;
      free_sum = '0;
    end else begin
      heap_formed = 1;
      heap_limit = h;
      unit_size[0] = 17'(h);
      unit_next[0] = 15'(NONE);
      unit_seen[0] = 1'b1;
      list_head = 0;
      free_sum = 17'(h - HEADER_BYTES);
    end
  endfunction

  function automatic void relink(int prev, int target);
    if (prev < NONE) begin
      unit_next[prev] = 15'(target);
      unit_seen[prev] = 1'b1;
    end else begin
      list_head = target;
    end
  endfunction

  // A free whose header unit was never written by the block is steered to a
  // misaligned offset, which is rejected before the header store is read.
  function automatic logic [15:0] known_offset(logic [15:0] d);
    int b;
    if (!heap_formed || d < HEADER_BYTES || d[1:0] != 2'b00) return d;
    b = int'(d) - HEADER_BYTES;
    if (b >= heap_limit) return d;
    if (unit_seen[b / ALIGN_BYTES]) return d;
    return d | 16'd1;
  endfunction

  // First-fit walk; the block is split when the tail can hold a header
  // plus the minimum split size.
  function automatic status_t model_alloc(logic [16:0] req, output logic [15:0] grant);
    int need, prev, cur, sz, rem, nxt, nu;
    grant = '0;
    if (!heap_formed || req == 0) return ST_NOFIT;
    need = ((int'(req) + ALIGN_BYTES - 1) & ~(ALIGN_BYTES - 1)) + HEADER_BYTES;
    prev = NONE;
    cur = list_head;
    while (cur < NONE) begin
      sz = unit_size[cur];
      if (sz >= need) begin
        rem = sz - need;
        nxt = unit_next[cur];
        nu = cur + need / ALIGN_BYTES;
        if (rem >= MIN_REM && nu < NONE) begin
          unit_size[nu] = rem;
          unit_used[nu] = 1'b0;
          unit_next[nu] = nxt;
          unit_seen[nu] = 1'b1;
          unit_size[cur] = need;
          relink(prev, nu);
          free_sum = free_sum - need;
        end else begin
          relink(prev, nxt);
          free_sum = free_sum - (sz - HEADER_BYTES);
        end
        unit_used[cur] = 1'b1;
        unit_next[cur] = NONE;
        unit_seen[cur] = 1'b1;
        alloc_tally++;
        grant = cur * ALIGN_BYTES + HEADER_BYTES;
        return ST_OK;
      end
      prev = cur;
      cur = unit_next[cur];
    end
    return ST_NOFIT;
  endfunction

  // Address-ordered insert, then merge with the following and the preceding
  // free block when they touch.
  function automatic status_t model_free(logic [15:0] d);
    int b, u, prev, cur, tail;
    if (!heap_formed || d < HEADER_BYTES || d[1:0] != 2'b00) return ST_BADPTR;
    b = int'(d) - HEADER_BYTES;
    if (b >= heap_limit) return ST_BADPTR;
    u = b / ALIGN_BYTES;
    if (!unit_used[u]) return ST_BADPTR;
    unit_used[u] = 1'b0;
    unit_seen[u] = 1'b1;
    free_sum = free_sum + unit_size[u] - HEADER_BYTES;
    free_tally++;
    prev = NONE;
    cur = list_head;
    while (cur < NONE && cur < u) begin
      prev = cur;
      cur = unit_next[cur];
    end
    unit_next[u] = cur;
    relink(prev, u);
    tail = u + unit_size[u] / ALIGN_BYTES;
    if (tail * ALIGN_BYTES < heap_limit && cur < NONE && cur == tail) begin
      unit_size[u] = unit_size[u] + unit_size[cur];
      unit_next[u] = unit_next[cur];
      free_sum = free_sum + HEADER_BYTES;
    end
    if (prev < NONE && prev + unit_size[prev] / ALIGN_BYTES == u) begin
      unit_size[prev] = unit_size[prev] + unit_size[u];
      unit_next[prev] = unit_next[u];
      free_sum = free_sum + HEADER_BYTES;
    end
    return ST_OK;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0d, expected %0d", $time, field, got, want);
    err_count++;
  endtask

  // Compare every output transfer with the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(status), 32'd0);
      end else begin
        want = pending_q.pop_front();
        if (status !== want.status)
          report_mismatch("status", 32'(status), 32'(want.status));
        if (granted_offset !== want.granted)
          report_mismatch("granted_offset", 32'(granted_offset), 32'(want.granted));
        if (free_byte_count !== want.free_bytes)
          report_mismatch("free_byte_count", 32'(free_byte_count), 32'(want.free_bytes));
        if (alloc_total !== want.allocs) report_mismatch("alloc_total", alloc_total, want.allocs);
        if (free_total !== want.frees) report_mismatch("free_total", free_total, want.frees);
      end
    end
  end

  // The receiver stalls at random, at the rate of the current phase.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Predict one request, then hold it on the input channel until the
  // transfer. Valid stays high afterwards so back-to-back items need no
  // drop; a gap lowers it first.
  task automatic run_item(logic f, logic [16:0] size, logic [15:0] offset,
                          bit typed = 0, status_t st = ST_OK, logic [15:0] gr = '0);
    result_t r;
    logic [15:0] grant;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    if (f == FUNC_ALLOC) begin
      r.status = model_alloc(size, grant);
      if (r.status == ST_OK) live_q.push_back(grant);
    end else begin
      grant = '0;
      r.status = model_free(offset);
    end
    r.granted = grant;
    r.free_bytes = free_sum;
    r.allocs = alloc_tally;
    r.frees = free_tally;
    if (typed) begin
      r.status = st;
      r.granted = gr;
    end
    pending_q.push_back(r);
    func <= f;
    request_size <= size;
    data_offset <= offset;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drain all results, let the block settle, then rewrite the heap size.
  task automatic write_heap_size(logic [16:0] value);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    heap_bytes <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    form_heap(value);
    live_q.delete();
  endtask

  task automatic random_item();
    int pick, k;
    logic [16:0] size;
    pick = $urandom_range(99);
    if (pick < 52 || (pick < 92 && live_q.size() == 0)) begin
      k = $urandom_range(99);
      if (k < 70) size = 17'($urandom_range(64, 1));
      else if (k < 85) size = 17'($urandom_range(2048, 65));
      else if (k < 90) size = '0;
      else if (k < 95) size = 17'($urandom_range(131071, 0));
      else size = (free_sum > 3) ? free_sum - 17'($urandom_range(3, 0)) : free_sum;
      run_item(FUNC_ALLOC, size, 16'($urandom_range(65535, 0)));
    end else if (pick < 92) begin
      k = $urandom_range(live_q.size() - 1, 0);
      size = 17'($urandom_range(131071, 0));
      run_item(FUNC_FREE, size, live_q[k]);
      live_q.delete(k);
    end else if (pick < 96 || live_q.size() == 0) begin
      // Noise pointer: any offset, aligned or not.
      run_item(FUNC_FREE, 17'($urandom_range(131071, 0)),
               known_offset(16'($urandom_range(65535, 0))));
    end else begin
      // Pointer into the middle of a live block or a block already freed.
      run_item(FUNC_FREE, '0,
               known_offset(live_q[$urandom_range(live_q.size() - 1, 0)] + 16'd4));
    end
  endtask

  initial begin
    dir_row_t rows [];
    logic [16:0] phase_sizes [4];
    rows = '{
      '{FUNC_ALLOC, 17'd0,      16'd0,     1, ST_NOFIT,  16'd0},
      '{FUNC_ALLOC, 17'd1,      16'd0,     1, ST_OK,     16'd8},
      '{FUNC_ALLOC, 17'd65536,  16'd0,     1, ST_NOFIT,  16'd0},
      '{FUNC_FREE,  17'd0,      16'd0,     1, ST_BADPTR, 16'd0},
      '{FUNC_FREE,  17'd0,      16'd4,     1, ST_BADPTR, 16'd0},
      '{FUNC_FREE,  17'd0,      16'd10,    1, ST_BADPTR, 16'd0},
      '{FUNC_FREE,  17'd0,      16'd65535, 1, ST_BADPTR, 16'd0},
      '{FUNC_FREE,  17'd0,      16'd20,    1, ST_BADPTR, 16'd0},
      '{FUNC_FREE,  17'd0,      16'd8,     1, ST_OK,     16'd0},
      '{FUNC_FREE,  17'd0,      16'd8,     1, ST_BADPTR, 16'd0},
      '{FUNC_ALLOC, 17'd65528,  16'd0,     1, ST_OK,     16'd8},
      '{FUNC_ALLOC, 17'd1,      16'd0,     1, ST_NOFIT,  16'd0},
      '{FUNC_FREE,  17'd131071, 16'd8,     1, ST_OK,     16'd0},
      '{FUNC_ALLOC, 17'd4,      16'd0,     0, ST_OK,     16'd0},
      '{FUNC_ALLOC, 17'd5,      16'd0,     0, ST_OK,     16'd0},
      '{FUNC_ALLOC, 17'd4,      16'd0,     0, ST_OK,     16'd0},
      '{FUNC_ALLOC, 17'd3,      16'd0,     0, ST_OK,     16'd0},
      '{FUNC_FREE,  17'd0,      16'd20,    0, ST_OK,     16'd0},
      '{FUNC_FREE,  17'd0,      16'd8,     0, ST_OK,     16'd0},
      '{FUNC_FREE,  17'd0,      16'd36,    0, ST_OK,     16'd0},
      '{FUNC_FREE,  17'd0,      16'd20,    0, ST_BADPTR, 16'd0}
    };
    phase_sizes = '{17'd65536, 17'd2000, 17'd300, 17'd131071};
    form_heap(HEAP_BYTES_RESET);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i])
      run_item(rows[i].func, rows[i].size, rows[i].offset,
               rows[i].typed, rows[i].status, rows[i].granted);

    // Smallest legal heap: one block, never split.
    write_heap_size(17'd16);
    run_item(FUNC_ALLOC, 17'd4, '0);
    run_item(FUNC_ALLOC, 17'd1, '0);
    run_item(FUNC_FREE, '0, 16'd8);
    // Heap too small to form, including zero.
    write_heap_size(17'd15);
    run_item(FUNC_ALLOC, 17'd4, '0);
    run_item(FUNC_FREE, '0, 16'd8);
    write_heap_size(17'd0);
    run_item(FUNC_ALLOC, 17'd1, '0);

    // Random phases, each on a fresh heap with its own idling pattern.
    for (int p = 0; p < 4; p++) begin
      write_heap_size(phase_sizes[p]);
      send_idle_pct  = (p == 1) ? 86 : (p == 3) ? 32 : 0;
      recv_stall_pct = (p == 2) ? 86 : (p == 3) ? 32 : 0;
      for (int n = 0; n < 305; n++) begin
        random_item();
        // Sender pause until the pipe is empty, once per phase.
        if (n == 150) begin
          in_valid <= 1'b0;
          while (pending_q.size() != 0) @(negedge clk);
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (50) @(posedge clk);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: generous bound well beyond the slowest legal run, with every
  // request walking the longest possible free list.
  initial begin
    #2000000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[sim.f]
rtl/ffha_pkg.sv
rtl/ffha_ram.sv
rtl/first_fit_heap_allocator.sv
bench/tb.sv
